// File: rtl/notification_attribute_tlv_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the notification attribute TLV parser
// Clocked property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_ATTRIBUTE_TLV_PARSER_ASSERT_SVH
`define NOTIFICATION_ATTRIBUTE_TLV_PARSER_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define NATP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("natp assertion failed");

// next-cycle implication, checked through reset as well
`define NATP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("natp assertion failed");

`endif

// File: rtl/natp_pkg.sv
// ----------------------------------------------------------------------------
// natp_pkg
// Shared types, constants and helpers of the notification attribute parser.
// ----------------------------------------------------------------------------
`default_nettype none

package natp_pkg;

  localparam int CAP_W   = 11;
  localparam int POS_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CAP_W-1:0] CAP_MAX          = 11'd1024;
  localparam logic [CAP_W-1:0] CAP_APP_ID_RST   = 11'd32;
  localparam logic [CAP_W-1:0] CAP_TITLE_RST    = 11'd64;
  localparam logic [CAP_W-1:0] CAP_SUBTITLE_RST = 11'd64;
  localparam logic [CAP_W-1:0] CAP_MESSAGE_RST  = 11'd256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APP_ID   = 2'd0,
    CFG_TITLE    = 2'd1,
    CFG_SUBTITLE = 2'd2,
    CFG_MESSAGE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_TERM   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  // everything one input byte produces: up to char, terminator, status
  typedef struct packed {
    logic              data_v;
    logic              term_v;
    logic              stat_v;
    logic              stat_acc;
    logic [1:0]        slot;
    logic [POS_W-1:0]  data_pos;
    logic [7:0]        data_char;
    logic [POS_W-1:0]  term_pos;
    logic [31:0]       uid;
  } natp_bundle_t;

  // queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } natp_qstat_t;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    eff_cap = (cap > CAP_MAX) ? CAP_MAX : cap;
  endfunction

endpackage

`default_nettype wire

// File: rtl/natp_front.sv
// ----------------------------------------------------------------------------
// natp_front
// Byte parser: command, uid, record headers and data; builds result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

module natp_front import natp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]     cfg_data,
  input  wire logic                 in_push,
  input  wire logic [7:0]           in_byte_value,
  input  wire logic                 in_packet_end,
  input  wire logic                 q_full,
  output      logic                 q_push,
  output      natp_bundle_t         q_bundle
);

  typedef enum logic [4:0] {
    PH_CMD  = 5'b00001,
    PH_UID  = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  logic [CAP_W-1:0] cap_r [4];

  phase_t      phase_r,  phase_nxt;
  logic [1:0]  hcnt_r,   hcnt_nxt;
  logic [31:0] uid_r,    uid_nxt;
  logic [7:0]  rid_r,    rid_nxt;
  logic [15:0] len_r,    len_nxt;
  logic [15:0] didx_r,   didx_nxt;
  logic [1:0]  hbs_r,    hbs_nxt;
  logic        rej_r,    rej_nxt;

  logic             accept;
  logic [CAP_W-1:0] cap_c;
  logic [CAP_W-1:0] cap_m1;
  logic [15:0]      term_len;
  logic [POS_W-1:0] kept;
  logic [15:0]      didx_inc;

  assign accept   = in_push && !q_full;
  assign cap_c    = (rid_r > 8'd3) ? '0 : eff_cap(cap_r[rid_r[1:0]]);
  assign cap_m1   = cap_c - 1'b1;
  assign didx_inc = didx_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r[CFG_APP_ID]   <= CAP_APP_ID_RST;
      cap_r[CFG_TITLE]    <= CAP_TITLE_RST;
      cap_r[CFG_SUBTITLE] <= CAP_SUBTITLE_RST;
      cap_r[CFG_MESSAGE]  <= CAP_MESSAGE_RST;
    end else if (cfg_we) begin
      cap_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    uid_nxt   = uid_r;
    rid_nxt   = rid_r;
    len_nxt   = len_r;
    didx_nxt  = didx_r;
    hbs_nxt   = hbs_r;
    rej_nxt   = rej_r;
    q_bundle  = '0;
    term_len  = len_r;
    q_bundle.slot      = rid_r[1:0];
    q_bundle.data_pos  = didx_r[POS_W-1:0];
    q_bundle.data_char = in_byte_value;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          if (in_byte_value != 8'd0) begin
            rej_nxt   = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_UID;
            hcnt_nxt  = '0;
            uid_nxt   = '0;
          end
        end
        PH_UID: begin
          unique case (hcnt_r)
            2'd0: uid_nxt = uid_r | {24'd0, in_byte_value};
            2'd1: uid_nxt = uid_r | {16'd0, in_byte_value, 8'd0};
            2'd2: uid_nxt = uid_r | {8'd0, in_byte_value, 16'd0};
            default: uid_nxt = uid_r | {in_byte_value, 24'd0};
          endcase
          if (hcnt_r == 2'd3) begin
            phase_nxt = PH_HDR;
            hbs_nxt   = '0;
          end else begin
            hcnt_nxt = hcnt_r + 2'd1;
          end
        end
        PH_HDR: begin
          unique case (hbs_r)
            2'd0: begin
              rid_nxt = in_byte_value;
              hbs_nxt = 2'd1;
            end
            2'd1: begin
              len_nxt = {8'd0, in_byte_value};
              hbs_nxt = 2'd2;
            end
            default: begin
              len_nxt  = {in_byte_value, len_r[7:0]};
              hbs_nxt  = '0;
              didx_nxt = '0;
              term_len = len_nxt;
              if (len_nxt == 16'd0) begin
                q_bundle.term_v = (cap_c != '0);
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          endcase
        end
        PH_DATA: begin
          q_bundle.data_v = (cap_c != '0) && (didx_r < {5'd0, cap_m1});
          didx_nxt = didx_inc;
          if (didx_inc >= len_r) begin
            q_bundle.term_v = (cap_c != '0);
            phase_nxt = PH_HDR;
            hbs_nxt   = '0;
          end
        end
        default: begin
        end
      endcase

      if (in_packet_end) begin
        q_bundle.stat_v   = 1'b1;
        q_bundle.stat_acc = !rej_nxt && (phase_nxt == PH_HDR);
        q_bundle.uid      = q_bundle.stat_acc ? uid_nxt : '0;
        phase_nxt = PH_CMD;
        hcnt_nxt  = '0;
        uid_nxt   = '0;
        rid_nxt   = '0;
        len_nxt   = '0;
        didx_nxt  = '0;
        hbs_nxt   = '0;
        rej_nxt   = 1'b0;
      end
    end
    kept = (term_len < {5'd0, cap_m1}) ? term_len[POS_W-1:0] : cap_m1[POS_W-1:0];
    q_bundle.term_pos = kept;
  end

  assign q_push = accept && (q_bundle.data_v || q_bundle.term_v || q_bundle.stat_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      hcnt_r  <= '0;
      uid_r   <= '0;
      rid_r   <= '0;
      len_r   <= '0;
      didx_r  <= '0;
      hbs_r   <= '0;
      rej_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      uid_r   <= uid_nxt;
      rid_r   <= rid_nxt;
      len_r   <= len_nxt;
      didx_r  <= didx_nxt;
      hbs_r   <= hbs_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/natp_queue.sv
// ----------------------------------------------------------------------------
// natp_queue
// Short FIFO of result bundles between parser and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module natp_queue import natp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire natp_bundle_t wr_bundle,
  input  wire logic         pop,
  output      natp_bundle_t rd_bundle,
  output      natp_qstat_t  qstat
);

  natp_bundle_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;
  logic              do_push, do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign rd_bundle   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/natp_back.sv
// ----------------------------------------------------------------------------
// natp_back
// Result sequencer: unpacks one bundle into up to three results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module natp_back import natp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire natp_bundle_t     rd_bundle,
  output      logic             q_pop,
  input  wire logic             out_pop,
  output      logic             out_empty,
  output      logic [1:0]       out_kind,
  output      logic [1:0]       out_slot,
  output      logic [POS_W-1:0] out_position,
  output      logic [7:0]       out_char_value,
  output      logic [31:0]      out_uid,
  output      logic             out_last_of_run
);

  // pending order: char, terminator, status
  logic [2:0]   pend_r, pend_nxt;
  natp_bundle_t bun_r;
  logic [2:0]   sel;
  logic         taken;

  assign out_empty       = (pend_r == '0);
  assign taken           = out_pop && !out_empty;
  assign out_last_of_run = ($countones(pend_r) == 1);
  assign q_pop           = !q_empty && (out_empty || (taken && out_last_of_run));

  always_comb begin
    sel            = 3'b000;
    out_kind       = KIND_CHAR;
    out_slot       = '0;
    out_position   = '0;
    out_char_value = '0;
    out_uid        = '0;
    priority if (pend_r[2]) begin
      sel            = 3'b100;
      out_slot       = bun_r.slot;
      out_position   = bun_r.data_pos;
      out_char_value = bun_r.data_char;
    end else if (pend_r[1]) begin
      sel          = 3'b010;
      out_kind     = KIND_TERM;
      out_slot     = bun_r.slot;
      out_position = bun_r.term_pos;
    end else if (pend_r[0]) begin
      sel      = 3'b001;
      out_kind = bun_r.stat_acc ? KIND_ACCEPT : KIND_REJECT;
      out_uid  = bun_r.uid;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (q_pop) begin
      pend_nxt = {rd_bundle.data_v, rd_bundle.term_v, rd_bundle.stat_v};
    end else if (taken) begin
      pend_nxt = pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bun_r <= rd_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/notification_attribute_tlv_parser.sv
// ----------------------------------------------------------------------------
// notification_attribute_tlv_parser
// Notification-attributes response parser: bytes in, string/status results out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_byte_value / in_packet_end with in_push; a
//   transaction completes on a clock edge with in_push high and in_full low.
//   Result queue: while out_empty is low the oldest result sits on the out_
//   ports; a transaction completes on an edge with out_pop high.
//   Configuration: cfg_we writes cfg_data into capacity register cfg_index
//   (0 app id, 1 title, 2 subtitle, 3 message); write only while idle.
// Timing:
//   One byte per cycle while in_full is low. A byte's results are queued as
//   one bundle on the accepting edge and loaded into the result register
//   once the result port is free. Two or three results from one byte hold the
//   result port in turn; the four-entry bundle queue absorbs that.
// Reset (rst_n low, synchronous): parser returns to "command byte expected",
//   queue and result register empty, capacities 32/64/64/256.
// Back-pressure: with out_pop low, in_full rises once four bundles wait
//   behind the one on the result ports; no transaction is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module notification_attribute_tlv_parser import natp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAP_W-1:0]     cfg_data,
  input  wire logic                 in_push,
  output      logic                 in_full,
  input  wire logic [7:0]           in_byte_value,
  input  wire logic                 in_packet_end,
  input  wire logic                 out_pop,
  output      logic                 out_empty,
  output      logic [1:0]           out_kind,
  output      logic [1:0]           out_slot,
  output      logic [POS_W-1:0]     out_position,
  output      logic [7:0]           out_char_value,
  output      logic [31:0]          out_uid,
  output      logic                 out_last_of_run
);

  natp_qstat_t  qstat;
  natp_bundle_t wr_bundle;
  natp_bundle_t rd_bundle;
  logic         q_push;
  logic         q_pop;

  assign in_full = qstat.full;

  // front: parse bytes, one bundle per result-producing byte
  natp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_byte_value (in_byte_value),
    .in_packet_end (in_packet_end),
    .q_full        (qstat.full),
    .q_push        (q_push),
    .q_bundle      (wr_bundle)
  );

  natp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_bundle (wr_bundle),
    .pop       (q_pop),
    .rd_bundle (rd_bundle),
    .qstat     (qstat)
  );

  // back: serialize bundles onto the result queue interface
  natp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (qstat.empty),
    .rd_bundle       (rd_bundle),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_kind        (out_kind),
    .out_slot        (out_slot),
    .out_position    (out_position),
    .out_char_value  (out_char_value),
    .out_uid         (out_uid),
    .out_last_of_run (out_last_of_run)
  );

`include "notification_attribute_tlv_parser_assert.svh"

  // status is always the final result of its byte
  `NATP_ASSERT_NOW(a_status_last,
    !out_empty && (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT),
    out_last_of_run)
  // string results never carry a uid
  `NATP_ASSERT_NOW(a_string_no_uid,
    !out_empty && (out_kind == KIND_CHAR || out_kind == KIND_TERM),
    out_uid == '0)
  // bundle queue never pushed while full
  `NATP_ASSERT_NOW(a_no_overflow, qstat.full, !q_push)
  // reset empties the result side
  `NATP_ASSERT_NEXT(a_reset_empty, !rst_n, out_empty)

endmodule

`default_nettype wire
